[design/assert_macros.svh]
// Assertion helpers shared by the RTL. Each macro builds a labeled concurrent
// assertion clocked on the rising edge and muted while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Consequent must hold in the same cycle as the antecedent.
`define ETF_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ETF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ETF_ASSERT_IMPL(label, clk, rst, ante, cons)
`define ETF_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[design/etf_pkg.sv]
package etf_pkg;

   localparam int FRAC_BITS_DEF  = 27;
   localparam int WORD_BITS_DEF  = 32;
   localparam int COUNT_BITS_DEF = 13;

   localparam int START_BITS     = 12;
   localparam int LIMIT_BITS     = 12;
   localparam int CSR_INDEX_BITS = 2;

   // |z|^2 escape level, in integer units
   localparam int ESCAPE_RADIUS_SQ = 4;

   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(80);

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_ITER_LIMIT = 2'd0,
      CSR_JULIA_MODE = 2'd1,
      CSR_JULIA_REAL = 2'd2,
      CSR_JULIA_IMAG = 2'd3
   } csr_index_type;

   // Operand pair routed to the shared multiplier
   typedef enum logic [1:0] {
      MUL_NONE = 2'd0,
      MUL_RR   = 2'd1,
      MUL_II   = 2'd2,
      MUL_RI   = 2'd3
   } mul_sel_type;

   typedef struct packed {
      logic        load;
      logic        inc;
      logic        update;
      logic        out_load;
      mul_sel_type mul_sel;
   } dp_cmd_type;

   typedef struct packed {
      logic limit_hit;
      logic escape;
   } dp_status_type;

endpackage

[design/escape_time_fractal_iterator_top.sv]
// Channel   Dir   Ports                                          Beat
// --------  ----  ---------------------------------------------  -----------------------------
// req       in    req_valid/req_ready, req_z_*, req_c_*,         one starting point and count
//                 req_start_count
// rsp       out   rsp_valid/rsp_ready, rsp_iterations            one final iteration count
// csr       in    csr_write_en, csr_index, csr_wdata             one register write, no wait
//
// Order: accept, one count step, then for each further step three products on
//    the shared multiplier and one update, and a post at the end. The limit
//    test ends the steps after a count step, the radius test at the third product.
// One item in flight; req_ready is high only in idle. The count waits in an
//    output register, so a new req beat is taken while rsp stalls.
// Reset clears the controller and loads limit 80, Mandelbrot, Julia const 0.
`include "assert_macros.svh"

module escape_time_fractal_iterator_top #(
   parameter int FRAC_BITS  = etf_pkg::FRAC_BITS_DEF,
   parameter int WORD_BITS  = etf_pkg::WORD_BITS_DEF,
   parameter int COUNT_BITS = etf_pkg::COUNT_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // input beat
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [WORD_BITS-1:0]         req_z_real,
   input  logic signed [WORD_BITS-1:0]         req_z_imag,
   input  logic signed [WORD_BITS-1:0]         req_c_real,
   input  logic signed [WORD_BITS-1:0]         req_c_imag,
   input  logic [etf_pkg::START_BITS-1:0]      req_start_count,
   // result beat
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [COUNT_BITS-1:0]               rsp_iterations,
   // register writes
   input  logic                                csr_write_en,
   input  logic [etf_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [WORD_BITS-1:0]                csr_wdata
);
   import etf_pkg::*;

   logic [LIMIT_BITS-1:0]       iter_limit_ff;
   logic                        julia_mode_ff;
   logic signed [WORD_BITS-1:0] julia_real_ff;
   logic signed [WORD_BITS-1:0] julia_imag_ff;

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   // Configuration registers: the user is to write them only while the block is idle (the block
   // does not enforce this), so the datapath may read them live for the whole item.
   always_ff @(posedge clock) begin
      if (reset) begin
         iter_limit_ff <= LIMIT_RESET;
         julia_mode_ff <= 1'b0;
         julia_real_ff <= '0;
         julia_imag_ff <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_ITER_LIMIT: iter_limit_ff <= csr_wdata[LIMIT_BITS-1:0];
            CSR_JULIA_MODE: julia_mode_ff <= csr_wdata[0];
            CSR_JULIA_REAL: julia_real_ff <= csr_wdata;
            CSR_JULIA_IMAG: julia_imag_ff <= csr_wdata;
            default: begin
               // drop writes to unmapped indexes
            end
         endcase
      end
   end

   // Sequencer: walks each iteration through the multiplier steps and
   // decides when to stop.
   etf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (dp_status),
      .cmd       (dp_cmd)
   );

   // Datapath: z, c and count registers, shared multiplier, radius test,
   // saturating update and the output count register.
   etf_dp #(
      .FRAC_BITS  (FRAC_BITS),
      .WORD_BITS  (WORD_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_dp (
      .clock            (clock),
      .cmd              (dp_cmd),
      .status           (dp_status),
      .z_real           (req_z_real),
      .z_imag           (req_z_imag),
      .c_real           (req_c_real),
      .c_imag           (req_c_imag),
      .start_count      (req_start_count),
      .iteration_limit  (iter_limit_ff),
      .julia_mode       (julia_mode_ff),
      .julia_const_real (julia_real_ff),
      .julia_const_imag (julia_imag_ff),
      .iterations       (rsp_iterations)
   );

   // An accepted beat keeps the block busy for at least the next cycle.
   `ETF_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)
   // The loop always takes at least one count step, so a zero count is a slip.
   `ETF_ASSERT_IMPL(a_count_nonzero, clock, reset, rsp_valid, rsp_iterations != '0)
   // A new result only comes out of a busy period.
   `ETF_ASSERT_IMPL(a_result_from_work, clock, reset, $rose(rsp_valid), $past(!req_ready))

endmodule

[design/etf_ctrl.sv]
module etf_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  etf_pkg::dp_status_type status,
   output etf_pkg::dp_cmd_type    cmd
);
   import etf_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_INC    = 7'b0000010,
      S_MUL_RR = 7'b0000100,
      S_MUL_II = 7'b0001000,
      S_MUL_RI = 7'b0010000,
      S_UPDATE = 7'b0100000,
      S_FINISH = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      out_valid_ff, out_valid_in;

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      cmd.mul_sel = MUL_NONE;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_INC;
            end
         end
         S_INC: begin
            cmd.inc  = 1'b1;
            state_in = status.limit_hit ? S_FINISH : S_MUL_RR;
         end
         S_MUL_RR: begin
            cmd.mul_sel = MUL_RR;
            state_in    = S_MUL_II;
         end
         S_MUL_II: begin
            cmd.mul_sel = MUL_II;
            state_in    = S_MUL_RI;
         end
         S_MUL_RI: begin
            // squares are in place: test the radius while re*im is formed
            cmd.mul_sel = MUL_RI;
            state_in    = status.escape ? S_FINISH : S_UPDATE;
         end
         S_UPDATE: begin
            cmd.update = 1'b1;
            cmd.inc    = 1'b1;
            state_in   = status.limit_hit ? S_FINISH : S_MUL_RR;
         end
         S_FINISH: begin
            if (!out_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign out_valid_in = cmd.out_load | (out_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = out_valid_ff;

endmodule

[design/etf_dp.sv]
module etf_dp #(
   parameter int FRAC_BITS  = etf_pkg::FRAC_BITS_DEF,
   parameter int WORD_BITS  = etf_pkg::WORD_BITS_DEF,
   parameter int COUNT_BITS = etf_pkg::COUNT_BITS_DEF
) (
   input  logic                               clock,
   input  etf_pkg::dp_cmd_type                cmd,
   output etf_pkg::dp_status_type             status,
   input  logic signed [WORD_BITS-1:0]        z_real,
   input  logic signed [WORD_BITS-1:0]        z_imag,
   input  logic signed [WORD_BITS-1:0]        c_real,
   input  logic signed [WORD_BITS-1:0]        c_imag,
   input  logic [etf_pkg::START_BITS-1:0]     start_count,
   input  logic [etf_pkg::LIMIT_BITS-1:0]     iteration_limit,
   input  logic                               julia_mode,
   input  logic signed [WORD_BITS-1:0]        julia_const_real,
   input  logic signed [WORD_BITS-1:0]        julia_const_imag,
   output logic [COUNT_BITS-1:0]              iterations
);
   import etf_pkg::*;

   localparam int PROD_BITS  = 2 * WORD_BITS;
   localparam int DIFF_BITS  = PROD_BITS + 1;
   localparam int RE_SUM_BITS = DIFF_BITS + 1;
   localparam int IM_SUM_BITS = PROD_BITS + 1;
   localparam int CMP_BITS   = (DIFF_BITS > 2 * FRAC_BITS + 3) ? DIFF_BITS : 2 * FRAC_BITS + 3;
   localparam int CNT_CMP_BITS = (COUNT_BITS > LIMIT_BITS) ? COUNT_BITS : LIMIT_BITS;
   localparam logic [CMP_BITS-1:0] ESCAPE_LEVEL =
      CMP_BITS'(ESCAPE_RADIUS_SQ) << (2 * FRAC_BITS);

   logic signed [WORD_BITS-1:0] re_ff, im_ff, cr_ff, ci_ff;
   logic [COUNT_BITS-1:0]       cnt_ff, iter_ff, cnt_inc;
   logic signed [PROD_BITS-1:0] rr_ff, ii_ff, ri_ff;
   logic signed [DIFF_BITS-1:0] diff_ff, diff_in, re_sh;
   logic [DIFF_BITS-1:0]        mag_sum;

   logic signed [WORD_BITS-1:0] mul_a, mul_b;
   logic signed [PROD_BITS-1:0] mul_a_ext, mul_b_ext, prod;
   logic signed [PROD_BITS-1:0] ri_sh;
   logic signed [RE_SUM_BITS-1:0] re_sum;
   logic signed [IM_SUM_BITS-1:0] im_sum;
   logic signed [WORD_BITS-1:0] re_next, im_next;

   // shared multiplier, one product per cycle
   always_comb begin
      case (cmd.mul_sel)
         MUL_RR: begin
            mul_a = re_ff;
            mul_b = re_ff;
         end
         MUL_II: begin
            mul_a = im_ff;
            mul_b = im_ff;
         end
         default: begin
            mul_a = re_ff;
            mul_b = im_ff;
         end
      endcase
   end

   assign mul_a_ext = {{WORD_BITS{mul_a[WORD_BITS-1]}}, mul_a};
   assign mul_b_ext = {{WORD_BITS{mul_b[WORD_BITS-1]}}, mul_b};
   assign prod      = mul_a_ext * mul_b_ext;

   // radius test and real-part difference, both exact
   assign mag_sum  = {1'b0, rr_ff} + {1'b0, ii_ff};
   assign diff_in  = {rr_ff[PROD_BITS-1], rr_ff} - {ii_ff[PROD_BITS-1], ii_ff};
   assign status.escape = (CMP_BITS'(mag_sum) >= ESCAPE_LEVEL);

   // floor shifts, add the constant, saturate to the word
   assign re_sh  = diff_ff >>> FRAC_BITS;
   assign ri_sh  = ri_ff >>> (FRAC_BITS - 1);
   assign re_sum = {re_sh[DIFF_BITS-1], re_sh}
                 + {{(RE_SUM_BITS-WORD_BITS){cr_ff[WORD_BITS-1]}}, cr_ff};
   assign im_sum = {ri_sh[PROD_BITS-1], ri_sh}
                 + {{(IM_SUM_BITS-WORD_BITS){ci_ff[WORD_BITS-1]}}, ci_ff};

   always_comb begin
      if (re_sum[RE_SUM_BITS-1:WORD_BITS-1] == '0 || re_sum[RE_SUM_BITS-1:WORD_BITS-1] == '1) begin
         re_next = re_sum[WORD_BITS-1:0];
      end else begin
         re_next = {re_sum[RE_SUM_BITS-1], {(WORD_BITS-1){~re_sum[RE_SUM_BITS-1]}}};
      end
      if (im_sum[IM_SUM_BITS-1:WORD_BITS-1] == '0 || im_sum[IM_SUM_BITS-1:WORD_BITS-1] == '1) begin
         im_next = im_sum[WORD_BITS-1:0];
      end else begin
         im_next = {im_sum[IM_SUM_BITS-1], {(WORD_BITS-1){~im_sum[IM_SUM_BITS-1]}}};
      end
   end

   assign cnt_inc          = cnt_ff + 1'b1;
   assign status.limit_hit = (CNT_CMP_BITS'(cnt_inc) >= CNT_CMP_BITS'(iteration_limit));

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         re_ff  <= z_real;
         im_ff  <= z_imag;
         cr_ff  <= julia_mode ? julia_const_real : c_real;
         ci_ff  <= julia_mode ? julia_const_imag : c_imag;
         cnt_ff <= COUNT_BITS'(start_count);
      end else begin
         if (cmd.inc) begin
            cnt_ff <= cnt_inc;
         end
         if (cmd.update) begin
            re_ff <= re_next;
            im_ff <= im_next;
         end
      end
      case (cmd.mul_sel)
         MUL_RR: begin
            rr_ff <= prod;
         end
         MUL_II: begin
            ii_ff <= prod;
         end
         MUL_RI: begin
            ri_ff   <= prod;
            diff_ff <= diff_in;
         end
         default: begin
         end
      endcase
      if (cmd.out_load) begin
         iter_ff <= cnt_ff;
      end
   end

   assign iterations = iter_ff;

endmodule
